// File: hw/rtl/imufr_pkg.sv
// Shared types and constants for the IMU frame parser and report reframer.
// Used by the parser, the report emitter, the top level and the checker.
`default_nettype none
package imufr_pkg;

  typedef enum logic [1:0] {
    REQ_RX    = 2'd0,
    REQ_ACCEL = 2'd1,
    REQ_RATE  = 2'd2,
    REQ_ANGLE = 2'd3
  } req_t;

  localparam logic [7:0] HDR_BYTE    = 8'h55;
  localparam logic [7:0] TYPE_ACCEL  = 8'h51;
  localparam logic [7:0] TYPE_RATE   = 8'h52;
  localparam logic [7:0] TYPE_ANGLE  = 8'h53;
  localparam logic [7:0] ID_ACCEL    = 8'h03;
  localparam logic [7:0] ID_RATE     = 8'h04;
  localparam logic [7:0] ID_ANGLE    = 8'h05;
  localparam logic [7:0] PAYLOAD_LEN = 8'h06;
  localparam logic [7:0] TAIL_BYTE   = 8'hBB;

  localparam int PAYLOAD_BYTES = 6;
  localparam int REC_W         = 8 * PAYLOAD_BYTES;

  // Byte positions within an eleven-byte frame, both directions.
  localparam logic [3:0] POS_HDR       = 4'd0;
  localparam logic [3:0] POS_KIND      = 4'd1;
  localparam logic [3:0] POS_LEN       = 4'd2;
  localparam logic [3:0] POS_PAY_FIRST = 4'd2;
  localparam logic [3:0] POS_PAY_LAST  = 4'd7;
  localparam logic [3:0] POS_LAST      = 4'd10;
  localparam logic [3:0] TX_PAY_FIRST  = 4'd3;
  localparam logic [3:0] TX_PAY_LAST   = 4'd8;
  localparam logic [3:0] TX_SUM        = 4'd9;

  typedef struct packed {
    logic [REC_W-1:0] accel;
    logic [REC_W-1:0] rate;
    logic [REC_W-1:0] angle;
  } records_t;

endpackage
`default_nettype wire

// File: hw/rtl/imufr_parser.sv
// Receive-side frame parser: hunts for the header, gathers the payload and
// commits it to the matching record at the eleventh byte. Uses imufr_pkg.
`default_nettype none
module imufr_parser (
  input  wire                clk,
  input  wire                rst,
  input  wire                byte_valid,
  input  wire  [7:0]         rx_byte,
  output imufr_pkg::records_t records
);
  import imufr_pkg::*;

  logic [3:0]       byte_count;
  logic [7:0]       frame_kind;
  logic [REC_W-1:0] payload_gather;
  records_t         recs;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count     <= '0;
      frame_kind     <= '0;
      payload_gather <= '0;
      recs           <= '0;
    end else if (byte_valid) begin
      for (int k = 0; k < PAYLOAD_BYTES; k++) begin
        if (byte_count == POS_PAY_FIRST + 4'(k)) begin
          payload_gather[8*k +: 8] <= rx_byte;
        end
      end
      if (byte_count == POS_KIND) begin
        frame_kind <= rx_byte;
      end
      if (byte_count == POS_HDR) begin
        if (rx_byte == HDR_BYTE) begin
          byte_count <= byte_count + 4'd1;
        end
      end else if (byte_count >= POS_LAST) begin
        byte_count <= '0;
        if (frame_kind == TYPE_ACCEL) begin
          recs.accel <= payload_gather;
        end else if (frame_kind == TYPE_RATE) begin
          recs.rate <= payload_gather;
        end else if (frame_kind == TYPE_ANGLE) begin
          recs.angle <= payload_gather;
        end
      end else begin
        byte_count <= byte_count + 4'd1;
      end
    end
  end

  assign records = recs;

endmodule
`default_nettype wire

// File: hw/rtl/imufr_emitter.sv
// Report emitter: snapshots one record on a send request and serializes the
// eleven-byte report into a registered output stage. Uses imufr_pkg.
`default_nettype none
module imufr_emitter (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 send_valid,
  input  imufr_pkg::req_t     send_kind,
  input  imufr_pkg::records_t records,
  output logic                send_ready,
  output logic                out_valid,
  input  wire                 out_ready,
  output logic [7:0]          out_byte,
  output logic                out_last
);
  import imufr_pkg::*;

  logic             busy;
  logic [3:0]       idx;
  logic [7:0]       id;
  logic [REC_W-1:0] rec;
  logic [7:0]       sum;
  logic             load;
  logic [7:0]       cur_byte;

  assign load       = busy && (!out_valid || out_ready);
  assign send_ready = !busy || (load && idx == POS_LAST);

  always_comb begin
    case (idx) inside
      POS_HDR:                     cur_byte = HDR_BYTE;
      POS_KIND:                    cur_byte = id;
      POS_LEN:                     cur_byte = PAYLOAD_LEN;
      [TX_PAY_FIRST:TX_PAY_LAST]:  cur_byte = rec[7:0];
      TX_SUM:                      cur_byte = sum;
      default:                     cur_byte = TAIL_BYTE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        out_byte  <= cur_byte;
        out_last  <= (idx == POS_LAST);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (send_valid && send_ready) begin
        busy <= 1'b1;
        idx  <= '0;
        sum  <= '0;
        unique case (send_kind)
          REQ_ACCEL: begin
            id  <= ID_ACCEL;
            rec <= records.accel;
          end
          REQ_RATE: begin
            id  <= ID_RATE;
            rec <= records.rate;
          end
          default: begin
            id  <= ID_ANGLE;
            rec <= records.angle;
          end
        endcase
      end else if (load) begin
        if (idx >= TX_PAY_FIRST && idx <= TX_PAY_LAST) begin
          sum <= sum + rec[7:0];
          rec <= rec >> 8;
        end
        if (idx == POS_LAST) begin
          busy <= 1'b0;
        end
        idx <= idx + 4'd1;
      end
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/imu_frame_parse_and_reframe.sv
// Top level of the IMU frame parser and report reframer.
// Instantiates imufr_parser and imufr_emitter; uses imufr_pkg.
//
// Usage: each input beat carries a request kind in s_axis_tuser and a
// received byte in s_axis_tdata. Kind 0 feeds the byte to the frame parser;
// such a beat produces no output. Kinds 1, 2 and 3 ask for a report of the
// latest acceleration, angular-rate or angle record, which leaves as eleven
// output beats with tlast on the closing byte.
// Received bytes are taken one per cycle while no report is in progress. A
// report request snapshots the record at its acceptance; its first byte appears
// once the serializer has loaded it into the output register, and one byte
// follows per cycle while the receiver is ready; the input is not ready till the report ends.
// The next request is taken in the same cycle the closing byte is loaded.
// When the receiver stalls, the output register holds its beat and the
// serializer waits; input stops once the report in progress is unfinished.
// Reset clears the parser count and all three records to zero and empties
// the output register.
`default_nettype none
module imu_frame_parse_and_reframe (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_axis_tvalid,
  output logic       s_axis_tready,
  input  wire  [7:0] s_axis_tdata,   // [7:0] rx_byte
  input  wire  [1:0] s_axis_tuser,   // [1:0] req_type
  output logic       m_axis_tvalid,
  input  wire        m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] tx_byte
  output logic       m_axis_tlast
);
  import imufr_pkg::*;

  req_t     req;
  records_t records;
  logic     send_ready;

  assign req           = req_t'(s_axis_tuser);
  assign s_axis_tready = send_ready;

  imufr_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (s_axis_tvalid && send_ready && req == REQ_RX),
    .rx_byte    (s_axis_tdata),
    .records    (records)
  );

  imufr_emitter u_emitter (
    .clk        (clk),
    .rst        (rst),
    .send_valid (s_axis_tvalid && req != REQ_RX),
    .send_kind  (req),
    .records    (records),
    .send_ready (send_ready),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_byte   (m_axis_tdata),
    .out_last   (m_axis_tlast)
  );

endmodule
`default_nettype wire

// File: hw/rtl/imufr_checker.sv
// Port-level checker for imu_frame_parse_and_reframe, bound to the top level.
// Depends on imufr_pkg for the frame byte constants.
`default_nettype none
module imufr_checker (
  input wire       clk,
  input wire       rst,
  input wire       m_axis_tvalid,
  input wire       m_axis_tready,
  input wire [7:0] m_axis_tdata,
  input wire       m_axis_tlast
);
  import imufr_pkg::*;

  logic at_start;

  always_ff @(posedge clk) begin
    if (rst) begin
      at_start <= 1'b1;
    end else if (m_axis_tvalid && m_axis_tready) begin
      at_start <= m_axis_tlast;
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("Output valid right after reset.");

  a_tail_byte: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata == TAIL_BYTE)
    else $error("Closing beat is not the tail byte.");

  a_header_first: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && at_start |-> m_axis_tdata == HDR_BYTE && !m_axis_tlast)
    else $error("Report does not open with the header byte.");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("Stalled output beat changed.");

endmodule

bind imu_frame_parse_and_reframe imufr_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

// File: tb/imufr_checker.sv
// Scoreboard for the IMU frame parser and report reframer: it watches both streams,
// predicts every report beat and compares it with what the block sends.
// Depends on imufr_pkg for request kinds, frame bytes and byte positions.
module imufr_scoreboard (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_axis_tvalid,
  input  wire        s_axis_tready,
  input  wire  [7:0] s_axis_tdata,   // [7:0] rx_byte
  input  wire  [1:0] s_axis_tuser,   // [1:0] req_type
  input  wire        m_axis_tvalid,
  input  wire        m_axis_tready,
  input  wire  [7:0] m_axis_tdata,   // [7:0] tx_byte
  input  wire        m_axis_tlast,
  output int         fail_count,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import imufr_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } tx_beat_t;

  tx_beat_t         report_q[$];
  logic [3:0]       frame_pos;
  logic [7:0]       frame_kind;
  logic [REC_W-1:0] gather;
  logic [REC_W-1:0] accel_rec;
  logic [REC_W-1:0] rate_rec;
  logic [REC_W-1:0] angle_rec;
  int               shown;

  task automatic absorb_rx_byte(input logic [7:0] b);
    if (frame_pos != POS_HDR || b == HDR_BYTE) begin
      if (frame_pos == POS_KIND) begin
        frame_kind = b;
      end else if (frame_pos >= POS_PAY_FIRST && frame_pos <= POS_PAY_LAST) begin
        gather[(frame_pos - POS_PAY_FIRST) * 8 +: 8] = b;
      end
      if (frame_pos == POS_LAST) begin
        case (frame_kind)
          TYPE_ACCEL: accel_rec = gather;
          TYPE_RATE:  rate_rec  = gather;
          TYPE_ANGLE: angle_rec = gather;
          default: ;
        endcase
        frame_pos = POS_HDR;
      end else begin
        frame_pos = frame_pos + 4'd1;
      end
    end
  endtask

  task automatic queue_report(input logic [7:0] id, input logic [REC_W-1:0] rec);
    logic [7:0] sum;
    sum = 8'h00;
    report_q.push_back('{HDR_BYTE, 1'b0});
    report_q.push_back('{id, 1'b0});
    report_q.push_back('{PAYLOAD_LEN, 1'b0});
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      sum = sum + rec[i * 8 +: 8];
      report_q.push_back('{rec[i * 8 +: 8], 1'b0});
    end
    report_q.push_back('{sum, 1'b0});
    report_q.push_back('{TAIL_BYTE, 1'b1});
  endtask

  always @(posedge clk) begin
    tx_beat_t want;
    if (rst) begin
      report_q.delete();
      frame_pos  = POS_HDR;
      frame_kind = 8'h00;
      gather     = '0;
      accel_rec  = '0;
      rate_rec   = '0;
      angle_rec  = '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (report_q.size() == 0) begin
          fail_count++;
          if (shown < 10) begin
            shown++;
            $display("%0t: unexpected beat data=%h last=%b", $realtime, m_axis_tdata,
                     m_axis_tlast);
          end
        end else begin
          want = report_q.pop_front();
          if (m_axis_tdata !== want.data || m_axis_tlast !== want.last) begin
            fail_count++;
            if (shown < 10) begin
              shown++;
              $display("%0t: beat mismatch: expected data=%h last=%b, got data=%h last=%b",
                       $realtime, want.data, want.last, m_axis_tdata, m_axis_tlast);
            end
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        case (req_t'(s_axis_tuser))
          REQ_RX:    absorb_rx_byte(s_axis_tdata);
          REQ_ACCEL: queue_report(ID_ACCEL, accel_rec);
          REQ_RATE:  queue_report(ID_RATE, rate_rec);
          default:   queue_report(ID_ANGLE, angle_rec);
        endcase
      end
    end
    pending = report_q.size();
  end

endmodule

// File: tb/imu_frame_parse_and_reframe_tb.sv
// Top of the testbench for imu_frame_parse_and_reframe: it drives received bytes and
// report requests with random gaps, stalls the report stream and gives the verdict.
// Depends on imufr_pkg, the block itself and imufr_scoreboard.
module imu_frame_parse_and_reframe_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import imufr_pkg::*;

  localparam int TARGET_BEATS = 430;
  localparam int CYCLE_LIMIT  = 800000;

  logic       clk;
  logic       rst;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;   // [7:0] rx_byte
  logic [1:0] s_axis_tuser;   // [1:0] req_type
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;   // [7:0] tx_byte
  logic       m_axis_tlast;
  int         fail_count;
  int         pending;
  int         beats_sent;
  int         cycles;
  bit         calm;

  imu_frame_parse_and_reframe dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  imufr_scoreboard u_scoreboard (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("imu_frame_parse_and_reframe_tb: errors");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] payload_byte();
    case ($urandom_range(0, 9))
      0:       return HDR_BYTE;
      1:       return 8'h00;
      2:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_beat(input req_t kind, input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = kind;
    s_axis_tdata  = b;
    do @(posedge clk); while (!s_axis_tready);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic send_request();
    case ($urandom_range(1, 3))
      1:       send_beat(REQ_ACCEL, 8'($urandom_range(0, 255)));
      2:       send_beat(REQ_RATE, 8'($urandom_range(0, 255)));
      default: send_beat(REQ_ANGLE, 8'($urandom_range(0, 255)));
    endcase
  endtask

  task automatic send_frame();
    logic [7:0] kind;
    int         r;
    r = $urandom_range(0, 99);
    if (r < 85) kind = TYPE_ACCEL + 8'($urandom_range(0, 2));
    else kind = 8'($urandom_range(0, 255));
    send_beat(REQ_RX, HDR_BYTE);
    for (int i = 1; i < 11; i++) begin
      if ($urandom_range(0, 99) < 6) send_request();
      send_beat(REQ_RX, (i == 1) ? kind : payload_byte());
    end
  endtask

  // Report stream: random stalls, mostly short, a few long, none while calm.
  initial begin
    int stall_left;
    m_axis_tready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0 && !calm) begin
        m_axis_tready = 1'b0;
        stall_left--;
      end else begin
        m_axis_tready = 1'b1;
        stall_left = 0;
        if (!calm && $urandom_range(0, 99) < 20) begin
          if ($urandom_range(0, 9) < 8) stall_left = $urandom_range(1, 3);
          else stall_left = $urandom_range(10, 40);
        end
      end
    end
  end

  initial begin
    int  r;
    bit  drained;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tuser  = REQ_RX;
    beats_sent    = 0;
    calm          = 1'b0;
    drained       = 1'b0;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    send_beat(REQ_ACCEL, 8'h00);
    send_beat(REQ_RATE, 8'hFF);
    send_beat(REQ_ANGLE, 8'hAA);
    send_beat(REQ_RX, 8'h00);
    send_beat(REQ_RX, 8'hFF);
    send_beat(REQ_RX, HDR_BYTE);
    send_beat(REQ_RX, TYPE_ACCEL);
    send_beat(REQ_RX, 8'hFF);
    send_beat(REQ_RX, HDR_BYTE);
    send_beat(REQ_RX, 8'h00);
    send_beat(REQ_RX, 8'hFF);
    send_beat(REQ_RX, 8'h80);
    send_beat(REQ_RX, 8'h7F);
    send_beat(REQ_RX, 8'h01);
    send_beat(REQ_RX, HDR_BYTE);
    send_beat(REQ_RX, 8'hFE);
    send_beat(REQ_ACCEL, 8'h55);
    send_beat(REQ_RATE, 8'h00);
    send_beat(REQ_ANGLE, 8'hFF);

    while (beats_sent < TARGET_BEATS) begin
      calm = (beats_sent > 150 && beats_sent < 220);
      if (!drained && beats_sent > 300) begin
        drained = 1'b1;
        s_axis_tvalid = 1'b0;
        while (pending != 0) @(negedge clk);
      end
      r = $urandom_range(0, 99);
      if (r < 55) send_frame();
      else if (r < 80) send_request();
      else if (r < 90) send_beat(REQ_RX, 8'($urandom_range(0, 255)));
      else begin
        send_beat(REQ_RX, HDR_BYTE);
        repeat ($urandom_range(0, 4)) send_beat(REQ_RX, payload_byte());
      end
    end
    calm = 1'b0;
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("imu_frame_parse_and_reframe_tb: clean");
    end else begin
      $display("imu_frame_parse_and_reframe_tb: errors");
    end
    $finish;
  end

endmodule
